// ===== rtl/per_cluster_gram_accumulator_unit_defines.svh =====
// Assertion macros for the per-cluster Gram accumulator.
// Included by the top level; depends on nothing else.
`ifndef PER_CLUSTER_GRAM_ACCUMULATOR_UNIT_DEFINES_SVH
`define PER_CLUSTER_GRAM_ACCUMULATOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PGACC_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("pgacc check failed");

// next-cycle implication, disabled during reset
`define PGACC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("pgacc check failed");

`endif

// ===== rtl/pgacc_pkg.sv =====
// Shared types and constants for the per-cluster Gram accumulator.
// No dependencies; used by every RTL file of the block except pgacc_ram.
package pgacc_pkg;

  localparam int VAL_W  = 16;
  localparam int PROD_W = 32;
  localparam int SUM_W  = 48;
  localparam int CFG_W  = 3;

  // command codes
  localparam logic [1:0] CMD_ACC   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic [1:0]              command;
    logic [5:0]              cluster;
    logic signed [VAL_W-1:0] value_0;
    logic signed [VAL_W-1:0] value_1;
    logic signed [VAL_W-1:0] value_2;
    logic signed [VAL_W-1:0] value_3;
  } in_word_t;

  typedef struct packed {
    logic [1:0]              row_index;
    logic [1:0]              col_index;
    logic signed [SUM_W-1:0] sum_value;
    logic                    last;
  } out_word_t;

  // per-lane strobes from the sequencer
  typedef struct packed {
    logic re;      // read the cluster's sum
    logic cap;     // capture the product of the new row
    logic acc_we;  // write back sum plus product
    logic clr_we;  // write zero
  } lane_ctrl_t;

  // slot of pair (h,j), h <= j, in row-major upper-triangle order
  function automatic int tri_index(int h, int j, int mc);
    return h * mc - (h * (h - 1)) / 2 + (j - h);
  endfunction

endpackage

// ===== rtl/pgacc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pgacc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/pgacc_lane.sv =====
// One product lane: owns the sums of a single column pair for all clusters.
// Depends on pgacc_pkg and pgacc_ram.
module pgacc_lane #(
  parameter int LJ           = 0,
  parameter int NUM_CLUSTERS = 64,
  parameter int AW           = 6
) (
  input  logic                                clk,
  input  pgacc_pkg::lane_ctrl_t               ctrl,
  input  logic [2:0]                          n_eff,
  input  logic signed [pgacc_pkg::VAL_W-1:0]  a,
  input  logic signed [pgacc_pkg::VAL_W-1:0]  b,
  input  logic [AW-1:0]                       raddr,
  input  logic [AW-1:0]                       waddr,
  output logic signed [pgacc_pkg::SUM_W-1:0]  sum
);
  import pgacc_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic [SUM_W-1:0]         rdata;
  logic signed [SUM_W:0]    sum_ext;
  logic signed [SUM_W-1:0]  sum_sat;
  logic signed [SUM_W-1:0]  wdata;
  logic                     active;
  logic                     we;

  // product of the new row, registered before the add
  always_ff @(posedge clk) begin
    if (ctrl.cap) begin
      prod_r <= a * b;
    end
  end

  assign sum = $signed(rdata);

  // saturating add of the stored sum and the product
  always_comb begin
    sum_ext = (SUM_W+1)'(sum) + (SUM_W+1)'(prod_r);
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_sat = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_ext[SUM_W-1:0];
    end
  end

  // pair takes part only while its higher column is active
  assign active = (3'(LJ) < n_eff);
  assign we     = ctrl.clr_we | (ctrl.acc_we & active);
  assign wdata  = ctrl.clr_we ? '0 : sum_sat;

  pgacc_ram #(
    .WIDTH (SUM_W),
    .DEPTH (NUM_CLUSTERS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ctrl.re),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

// ===== rtl/pgacc_merge.sv =====
// Merging stage: picks the lane holding matrix entry (h,j), mirroring
// the lower triangle onto the stored upper one. Depends on pgacc_pkg.
module pgacc_merge #(
  parameter int MAX_COLS = 4,
  parameter int TRI      = 10
) (
  input  logic signed [pgacc_pkg::SUM_W-1:0] sums [TRI],
  input  logic [1:0]                         h,
  input  logic [1:0]                         j,
  output logic signed [pgacc_pkg::SUM_W-1:0] sel
);
  import pgacc_pkg::*;

  logic [1:0]     lo;
  logic [1:0]     hi;
  logic [TRI-1:0] hit;

  assign lo = (h < j) ? h : j;
  assign hi = (h < j) ? j : h;

  // one match line per stored pair
  for (genvar ga = 0; ga < MAX_COLS; ga++) begin : g_row
    for (genvar gb = ga; gb < MAX_COLS; gb++) begin : g_col
      localparam int K = tri_index(ga, gb, MAX_COLS);
      assign hit[K] = (lo == 2'(ga)) && (hi == 2'(gb));
    end
  end

  // and-or select
  always_comb begin
    sel = '0;
    for (int k = 0; k < TRI; k++) begin
      sel = sel | (hit[k] ? sums[k] : '0);
    end
  end

endmodule

// ===== rtl/per_cluster_gram_accumulator_unit.sv =====
// Top level of the per-cluster Gram accumulator: sequencer, lanes, merge.
// Depends on pgacc_pkg, pgacc_lane, pgacc_merge and the defines header.
//
//  channel | ports                         | dir | word
//  --------+-------------------------------+-----+---------------------------
//  in      | in_valid  in_ready  in_word   | in  | command, cluster, value_0..3
//  out     | out_valid out_ready out_word  | out | row, col, sum, last
//  cfg     | cfg_valid cfg_ready cfg_data  | in  | cols_in_use
//
// Accumulate: accept and lane read, then saturating write-back in S_ACC;
// each lane RAM has one read and one write port, so a row is a read-modify-write.
// Clear: zeroes the cluster's sums on acceptance. Read: n*n output words, one per cycle unless out_ready stalls.
// After reset the lanes are swept to zero over all NUM_CLUSTERS addresses; in_ready is low.
// A finished word waits in the output register; out_ready low stalls only the readout.
`include "per_cluster_gram_accumulator_unit_defines.svh"

module per_cluster_gram_accumulator_unit #(
  parameter int NUM_CLUSTERS = 64,
  parameter int MAX_COLS     = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pgacc_pkg::in_word_t   in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pgacc_pkg::out_word_t  out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [pgacc_pkg::CFG_W-1:0] cfg_data
);
  import pgacc_pkg::*;

  localparam int AW  = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
  localparam int TRI = (MAX_COLS * (MAX_COLS + 1)) / 2;

  typedef enum logic [3:0] {
    S_CLR  = 4'b0001,
    S_IDLE = 4'b0010,
    S_ACC  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [AW-1:0]           clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0]           addr_r, addr_nxt;
  logic [CFG_W-1:0]        cols_r;
  logic [1:0]              h_r, h_nxt;
  logic [1:0]              j_r, j_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_word_t               out_word_r, out_word_nxt;

  logic [2:0]              n_eff;
  logic                    accept;
  logic                    cl_ok;
  logic [AW-1:0]           cl_addr;
  logic                    emit_load;
  logic                    j_end;
  logic                    last_entry;
  logic [AW-1:0]           waddr;
  lane_ctrl_t              ctrl;
  logic signed [VAL_W-1:0] vals [4];
  logic signed [SUM_W-1:0] lane_sum [TRI];
  logic signed [SUM_W-1:0] sel_sum;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= 3'd4;
    end else if (cfg_valid && cfg_ready) begin
      cols_r <= cfg_data;
    end
  end

  // effective column count, clamped to 1..MAX_COLS
  always_comb begin
    if (cols_r == '0) begin
      n_eff = 3'd1;
    end else if (cols_r > 3'(MAX_COLS)) begin
      n_eff = 3'(MAX_COLS);
    end else begin
      n_eff = cols_r;
    end
  end

  // input decode
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign cl_ok    = (32'(in_word.cluster) < NUM_CLUSTERS);
  assign cl_addr  = AW'(in_word.cluster);

  assign vals[0] = in_word.value_0;
  assign vals[1] = in_word.value_1;
  assign vals[2] = in_word.value_2;
  assign vals[3] = in_word.value_3;

  // lane strobes
  always_comb begin
    ctrl.re     = accept;
    ctrl.cap    = accept;
    ctrl.acc_we = (state_r == S_ACC);
    ctrl.clr_we = (state_r == S_CLR) ||
                  (accept && cl_ok && (in_word.command == CMD_CLEAR));
    if (state_r == S_CLR) begin
      waddr = clr_cnt_r;
    end else if (state_r == S_ACC) begin
      waddr = addr_r;
    end else begin
      waddr = cl_addr;
    end
  end

  // readout walk
  assign j_end      = ({1'b0, j_r} == n_eff - 3'd1);
  assign last_entry = j_end && ({1'b0, h_r} == n_eff - 3'd1);
  assign emit_load  = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    addr_nxt      = addr_r;
    h_nxt         = h_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(NUM_CLUSTERS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && cl_ok) begin
          addr_nxt = cl_addr;
          h_nxt    = 2'd0;
          j_nxt    = 2'd0;
          if (in_word.command == CMD_ACC) begin
            state_nxt = S_ACC;
          end else if (in_word.command == CMD_READ) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_ACC: begin
        state_nxt = S_IDLE;
      end
      S_EMIT: begin
        if (emit_load) begin
          out_valid_nxt          = 1'b1;
          out_word_nxt.row_index = h_r;
          out_word_nxt.col_index = j_r;
          out_word_nxt.sum_value = sel_sum;
          out_word_nxt.last      = last_entry;
          if (j_end) begin
            j_nxt = 2'd0;
            h_nxt = h_r + 2'd1;
          end else begin
            j_nxt = j_r + 2'd1;
          end
          if (last_entry) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and walk registers
  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    h_r        <= h_nxt;
    j_r        <= j_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // one lane per upper-triangle pair
  for (genvar gh = 0; gh < MAX_COLS; gh++) begin : g_lh
    for (genvar gj = gh; gj < MAX_COLS; gj++) begin : g_lj
      localparam int K = tri_index(gh, gj, MAX_COLS);
      pgacc_lane #(
        .LJ           (gj),
        .NUM_CLUSTERS (NUM_CLUSTERS),
        .AW           (AW)
      ) u_lane (
        .clk   (clk),
        .ctrl  (ctrl),
        .n_eff (n_eff),
        .a     (vals[gh]),
        .b     (vals[gj]),
        .raddr (cl_addr),
        .waddr (waddr),
        .sum   (lane_sum[K])
      );
    end
  end

  pgacc_merge #(
    .MAX_COLS (MAX_COLS),
    .TRI      (TRI)
  ) u_merge (
    .sums (lane_sum),
    .h    (h_r),
    .j    (j_r),
    .sel  (sel_sum)
  );

  // checks
  `PGACC_ASSERT_NEXT(a_last_ends_read, clk, rst_n, emit_load && last_entry, state_r == S_IDLE)
  `PGACC_ASSERT_NOW(a_no_out_in_sweep, clk, rst_n, state_r == S_CLR, !out_valid_r)
  `PGACC_ASSERT_NOW(a_last_on_diag, clk, rst_n, out_valid_r && out_word_r.last, out_word_r.row_index == out_word_r.col_index)

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for per_cluster_gram_accumulator_unit: random and directed rows, reads, clears.
// A scoreboard class predicts every matrix word; depends on pgacc_pkg and the RTL only.

// Predicts the per-cluster upper-triangle sums and checks readout words in order
class gram_scoreboard;
  localparam int CLUSTERS  = 64;
  localparam int COLS      = 4;
  localparam int SLOTS     = 10;

  logic signed [47:0]   sums [CLUSTERS][SLOTS];
  int                   slot_of [COLS][COLS];
  logic [2:0]           cols_reg;
  pgacc_pkg::out_word_t expected_q [$];
  int                   errors;

  function new();
    int k;
    k = 0;
    // (h,j) and (j,h) share one stored sum
    for (int h = 0; h < COLS; h++) begin
      for (int j = h; j < COLS; j++) begin
        slot_of[h][j] = k;
        slot_of[j][h] = k;
        k++;
      end
    end
    foreach (sums[c, s]) sums[c][s] = '0;
    cols_reg = 3'd4;
    errors = 0;
  endfunction

  function int active_cols();
    if (cols_reg == 3'd0) return 1;
    if (cols_reg > COLS) return COLS;
    return int'(cols_reg);
  endfunction

  function void set_cols(logic [2:0] v);
    cols_reg = v;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // update sums or queue readout words for one accepted input word
  function void note_input(pgacc_pkg::in_word_t w);
    logic signed [15:0]   v [COLS];
    longint               acc;
    int                   n;
    int                   c;
    pgacc_pkg::out_word_t e;
    n = active_cols();
    c = int'(w.cluster);
    if (c >= CLUSTERS) return;
    v[0] = w.value_0;
    v[1] = w.value_1;
    v[2] = w.value_2;
    v[3] = w.value_3;
    case (w.command)
      pgacc_pkg::CMD_ACC: begin
        for (int h = 0; h < n; h++) begin
          for (int j = h; j < n; j++) begin
            acc = longint'(sums[c][slot_of[h][j]]) + longint'(v[h]) * longint'(v[j]);
            if (acc > longint'(pgacc_pkg::SUM_MAX)) acc = longint'(pgacc_pkg::SUM_MAX);
            if (acc < longint'(pgacc_pkg::SUM_MIN)) acc = longint'(pgacc_pkg::SUM_MIN);
            sums[c][slot_of[h][j]] = acc[47:0];
          end
        end
      end
      pgacc_pkg::CMD_CLEAR: begin
        for (int s = 0; s < SLOTS; s++) sums[c][s] = '0;
      end
      pgacc_pkg::CMD_READ: begin
        for (int h = 0; h < n; h++) begin
          for (int j = 0; j < n; j++) begin
            e.row_index = 2'(h);
            e.col_index = 2'(j);
            e.sum_value = sums[c][slot_of[h][j]];
            e.last      = (h == n - 1) && (j == n - 1);
            expected_q.push_back(e);
          end
        end
      end
      default: ;  // spare command: no effect
    endcase
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // compare one accepted output word against the oldest prediction
  task check_result(pgacc_pkg::out_word_t got);
    pgacc_pkg::out_word_t e;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected word row %0d col %0d sum %0d last %0d",
                       got.row_index, got.col_index, $signed(got.sum_value), got.last));
      return;
    end
    e = expected_q.pop_front();
    if (got.row_index !== e.row_index)
      report($sformatf("row_index got %0d want %0d", got.row_index, e.row_index));
    if (got.col_index !== e.col_index)
      report($sformatf("col_index got %0d want %0d", got.col_index, e.col_index));
    if (got.sum_value !== e.sum_value)
      report($sformatf("sum_value at (%0d,%0d) got %0d want %0d", e.row_index, e.col_index,
                       $signed(got.sum_value), $signed(e.sum_value)));
    if (got.last !== e.last)
      report($sformatf("last at (%0d,%0d) got %0d want %0d", e.row_index, e.col_index,
                       got.last, e.last));
  endtask
endclass

module testbench;
  import pgacc_pkg::*;

  localparam logic [1:0]  CMD_SPARE    = 2'd3;
  localparam int          IDLE_LIMIT   = 4000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          HOLD_CYCLES  = 600;
  localparam int          SAT_ROWS     = 16;
  localparam int          PHASE_ITEMS  = 47;
  localparam logic signed [15:0] VMAX  = 16'sh7FFF;
  localparam logic signed [15:0] VMIN  = 16'sh8000;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_mode_e;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_word_t         in_word = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_word_t        out_word;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             hold_request = 1'b0;
  int               idle_count = 0;
  gram_scoreboard   board;

  per_cluster_gram_accumulator_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // output monitor and stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && out_ready) board.check_result(out_word);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) ||
          (cfg_valid && cfg_ready === 1'b1)) begin
        idle_count <= 0;
      end else if (idle_count >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_count <= idle_count + 1;
      end
    end
  end

  // receiver: segments of different stall patterns, one long hold-off on request
  initial begin : receiver
    ready_mode_e mode;
    int          span;
    int          tick;
    bit          hold_done;
    hold_done = 1'b0;
    tick = 0;
    @(posedge clk);
    forever begin
      mode = ready_mode_e'($urandom_range(0, 3));
      span = $urandom_range(10, 150);
      repeat (span) begin
        if (hold_request && !hold_done) begin
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_done = 1'b1;
        end
        case (mode)
          READY_ALWAYS:  out_ready <= 1'b1;
          READY_COIN:    out_ready <= 1'($urandom_range(0, 1));
          READY_SPARSE:  out_ready <= ($urandom_range(0, 7) == 0);
          default:       out_ready <= ((tick % 6) < 3);
        endcase
        tick++;
        @(posedge clk);
      end
    end
  end

  function automatic in_word_t make_item(logic [1:0] cmd, logic [5:0] cl,
                                         logic signed [15:0] a, logic signed [15:0] b,
                                         logic signed [15:0] c, logic signed [15:0] d);
    in_word_t w;
    w.command = cmd;
    w.cluster = cl;
    w.value_0 = a;
    w.value_1 = b;
    w.value_2 = c;
    w.value_3 = d;
    return w;
  endfunction

  function automatic logic signed [15:0] random_value();
    logic signed [15:0] r;
    case ($urandom_range(0, 4))
      0: r = VMAX;
      1: r = VMIN;
      2: begin
        r = 16'($urandom_range(0, 31));
        r = r - 16'sd16;
      end
      default: r = 16'($urandom);
    endcase
    return r;
  endfunction

  // mostly rows on a few hot clusters, with reads, clears and spare commands mixed in
  function automatic in_word_t random_item();
    in_word_t w;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 62) w.command = CMD_ACC;
    else if (pick < 84) w.command = CMD_READ;
    else if (pick < 92) w.command = CMD_CLEAR;
    else w.command = CMD_SPARE;
    if ($urandom_range(0, 3) != 0) w.cluster = 6'($urandom_range(0, 3));
    else w.cluster = 6'($urandom);
    w.value_0 = random_value();
    w.value_1 = random_value();
    w.value_2 = random_value();
    w.value_3 = random_value();
    return w;
  endfunction

  // offer one input word and hold it until accepted
  task automatic send_item(in_word_t w);
    in_word <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    board.note_input(w);
  endtask

  task automatic pause_sender(int n);
    logic [$bits(in_word_t)-1:0] junk;
    if (n > 0) begin
      junk = $bits(in_word_t)'({$urandom, $urandom, $urandom});
      in_valid <= 1'b0;
      in_word <= junk;
      repeat (n) @(posedge clk);
    end
  endtask

  // all predicted words out, then let in-flight write-backs settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cols(logic [CFG_W-1:0] v);
    wait_idle();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    board.set_cols(v);
    cfg_valid <= 1'b0;
  endtask

  // bursts of random words with random gaps, count words in total
  task automatic run_random_phase(int count);
    int       done_n;
    int       burst;
    in_word_t w;
    done_n = 0;
    while (done_n < count) begin
      burst = $urandom_range(1, 16);
      if (burst > count - done_n) burst = count - done_n;
      repeat (burst) begin
        w = random_item();
        send_item(w);
        done_n++;
      end
      pause_sender($urandom_range(0, 12));
    end
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] phase_cols [9];
    phase_cols = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd7, 3'd5, 3'd6, 3'd4};
    board = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: fresh cluster, extremes, read right after rows, spare, clear
    send_item(make_item(CMD_READ, 6'd5, 0, 0, 0, 0));
    send_item(make_item(CMD_ACC, 6'd5, VMAX, VMIN, 16'sd1, -16'sd1));
    send_item(make_item(CMD_ACC, 6'd5, VMIN, VMIN, VMIN, VMIN));
    send_item(make_item(CMD_READ, 6'd5, 0, 0, 0, 0));
    send_item(make_item(CMD_ACC, 6'd63, 16'sh1234, -16'sh0F0F, 16'sh5A5A, -16'sd3));
    send_item(make_item(CMD_READ, 6'd63, 0, 0, 0, 0));
    send_item(make_item(CMD_SPARE, 6'd5, VMAX, VMAX, VMAX, VMAX));
    send_item(make_item(CMD_READ, 6'd5, 0, 0, 0, 0));
    send_item(make_item(CMD_CLEAR, 6'd5, VMIN, VMIN, VMIN, VMIN));
    send_item(make_item(CMD_READ, 6'd5, 0, 0, 0, 0));
    send_item(make_item(CMD_ACC, 6'd0, 16'sd100, -16'sd200, 16'sd300, -16'sd400));
    send_item(make_item(CMD_ACC, 6'd0, 16'sd7, 16'sd7, 16'sd7, 16'sd7));
    send_item(make_item(CMD_READ, 6'd0, 0, 0, 0, 0));
    // two columns: upper columns keep their sums and values there are ignored
    write_cols(3'd2);
    send_item(make_item(CMD_ACC, 6'd0, 16'sd5, 16'sd6, VMAX, VMIN));
    send_item(make_item(CMD_READ, 6'd0, 0, 0, 0, 0));
    // zero acts as one column
    write_cols(3'd0);
    send_item(make_item(CMD_READ, 6'd0, 0, 0, 0, 0));
    send_item(make_item(CMD_ACC, 6'd0, VMIN, VMAX, VMAX, VMAX));
    send_item(make_item(CMD_READ, 6'd0, 0, 0, 0, 0));
    // above the maximum acts as four: hidden sums come back
    write_cols(3'd7);
    send_item(make_item(CMD_READ, 6'd0, 0, 0, 0, 0));
    send_item(make_item(CMD_CLEAR, 6'd0, 0, 0, 0, 0));
    send_item(make_item(CMD_READ, 6'd0, 0, 0, 0, 0));

    // extreme rows: large positive diagonal sums, large cross sums of both signs
    write_cols(3'd4);
    send_item(make_item(CMD_CLEAR, 6'd9, 0, 0, 0, 0));
    repeat (SAT_ROWS) send_item(make_item(CMD_ACC, 6'd9, VMIN, VMAX, VMIN, VMAX));
    send_item(make_item(CMD_READ, 6'd9, 0, 0, 0, 0));
    // four of the six cross sums move the other way
    repeat (8) send_item(make_item(CMD_ACC, 6'd9, VMIN, VMIN, VMAX, VMAX));
    send_item(make_item(CMD_READ, 6'd9, 0, 0, 0, 0));
    send_item(make_item(CMD_CLEAR, 6'd9, 0, 0, 0, 0));
    send_item(make_item(CMD_READ, 6'd9, 0, 0, 0, 0));

    // random phases over column settings; one long receiver hold-off
    for (int p = 0; p < 9; p++) begin
      write_cols(phase_cols[p]);
      if (p == 3) hold_request <= 1'b1;
      run_random_phase(PHASE_ITEMS);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
